// File: src/vfc_pkg.sv
// Types, codes and constants shared by the voxel face cull core.
package vfc_pkg;

  localparam logic [7:0] TRANSPARENT_RESET = 8'd5;
  localparam logic [7:0] AIR_TYPE          = 8'd0;
  localparam int         QUEUE_DEPTH       = 4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [2:0] FACE_BACK   = 3'd0;
  localparam logic [2:0] FACE_FRONT  = 3'd1;
  localparam logic [2:0] FACE_LEFT   = 3'd2;
  localparam logic [2:0] FACE_RIGHT  = 3'd3;
  localparam logic [2:0] FACE_TOP    = 3'd4;
  localparam logic [2:0] FACE_BOTTOM = 3'd5;

  // Where a face's neighbor type comes from.
  typedef enum logic [1:0] {
    SRC_MEM    = 2'd0,
    SRC_EDGE_X = 2'd1,
    SRC_EDGE_Z = 2'd2,
    SRC_AIR    = 2'd3
  } vfc_src_t;

  typedef enum logic [1:0] {
    BS_IDLE = 2'd0,
    BS_READ = 2'd1,
    BS_EMIT = 2'd2
  } vfc_bstate_t;

  typedef struct packed {
    logic       func;
    logic [3:0] pos_x;
    logic [7:0] pos_y;
    logic [3:0] pos_z;
    logic [7:0] block_type;
    logic [7:0] edge_x_type;
    logic [7:0] edge_z_type;
  } vfc_in_t;

  typedef struct packed {
    logic [3:0] out_x;
    logic [7:0] out_y;
    logic [3:0] out_z;
    logic [2:0] face_id;
    logic       face_valid;
    logic       last_face;
  } vfc_out_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    logic                 func;
    logic                 in_chunk;
    logic [3:0]           pos_x;
    logic [7:0]           pos_y;
    logic [3:0]           pos_z;
    logic [7:0]           block_type;
    logic [7:0]           edge_x_type;
    logic [7:0]           edge_z_type;
    vfc_src_t [5:0]       src;
  } vfc_cmd_t;

  // Neighbor source for a read step: step 0 is the cell itself, steps 1..6 are faces 0..5.
  function automatic vfc_src_t src_of_step(input vfc_src_t [5:0] src, input logic [2:0] step);
    vfc_src_t s;
    case (step)
      3'd1:    s = src[0];
      3'd2:    s = src[1];
      3'd3:    s = src[2];
      3'd4:    s = src[3];
      3'd5:    s = src[4];
      3'd6:    s = src[5];
      default: s = SRC_MEM;
    endcase
    return s;
  endfunction

endpackage

// File: src/vfc_front.sv
// Front end: range check and neighbor source classification of an input word.
module vfc_front #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_HEIGHT = 256,
  parameter int CHUNK_DEPTH  = 16
) (
  input  vfc_pkg::vfc_in_t  in_data,
  output vfc_pkg::vfc_cmd_t cmd
);
  import vfc_pkg::*;

  logic in_x, in_y, in_z;

  assign in_x = int'(in_data.pos_x) < CHUNK_WIDTH;
  assign in_y = int'(in_data.pos_y) < CHUNK_HEIGHT;
  assign in_z = int'(in_data.pos_z) < CHUNK_DEPTH;

  always_comb begin
    cmd             = '0;
    cmd.func        = in_data.func;
    cmd.in_chunk    = in_x && in_y && in_z;
    cmd.pos_x       = in_data.pos_x;
    cmd.pos_y       = in_data.pos_y;
    cmd.pos_z       = in_data.pos_z;
    cmd.block_type  = in_data.block_type;
    cmd.edge_x_type = in_data.edge_x_type;
    cmd.edge_z_type = in_data.edge_z_type;
    // Across a side edge take the host's type, past top or bottom take air.
    cmd.src[FACE_BACK]   = (in_data.pos_z == 4'd0) ? SRC_EDGE_Z : SRC_MEM;
    cmd.src[FACE_FRONT]  = (int'(in_data.pos_z) + 1 >= CHUNK_DEPTH) ? SRC_EDGE_Z : SRC_MEM;
    cmd.src[FACE_LEFT]   = (in_data.pos_x == 4'd0) ? SRC_EDGE_X : SRC_MEM;
    cmd.src[FACE_RIGHT]  = (int'(in_data.pos_x) + 1 >= CHUNK_WIDTH) ? SRC_EDGE_X : SRC_MEM;
    cmd.src[FACE_TOP]    = (int'(in_data.pos_y) + 1 >= CHUNK_HEIGHT) ? SRC_AIR : SRC_MEM;
    cmd.src[FACE_BOTTOM] = (in_data.pos_y == 8'd0) ? SRC_AIR : SRC_MEM;
  end

endmodule

// File: src/vfc_queue.sv
// Short command queue between the front end and the back end.
module vfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_stall,
  input  vfc_pkg::vfc_cmd_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output vfc_pkg::vfc_cmd_t pop_data
);
  import vfc_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  vfc_cmd_t        entry_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_stall = (count_r == CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/vfc_back.sv
// Back end: voxel memory, per-face read sequencer and result register.
module vfc_back #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_HEIGHT = 256,
  parameter int CHUNK_DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        transparent_type,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  vfc_pkg::vfc_cmd_t pop_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vfc_pkg::vfc_out_t out_data
);
  import vfc_pkg::*;

  localparam int CELL_COUNT = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_DEPTH;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int STRIDE_Z   = CHUNK_WIDTH;
  localparam int STRIDE_Y   = CHUNK_WIDTH * CHUNK_DEPTH;
  localparam logic [AW-1:0] STEP_X = AW'(1);
  localparam logic [AW-1:0] STEP_Z = AW'(STRIDE_Z);
  localparam logic [AW-1:0] STEP_Y = AW'(STRIDE_Y);
  localparam logic [2:0]    LAST_STEP = 3'd6;
  localparam logic [2:0]    STEP_DONE = 3'd7;

  logic [7:0]    voxel_mem_r [CELL_COUNT];
  logic [7:0]    rd_data_r;

  vfc_bstate_t   state_r, state_nxt;
  vfc_cmd_t      cur_r, cur_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [2:0]    step_r, step_nxt;
  logic          dvld_r, dvld_nxt;
  logic [2:0]    dstep_r, dstep_nxt;
  logic [7:0]    self_r, self_nxt;
  logic [5:0]    mask_r, mask_nxt;
  logic          out_valid_r, out_valid_nxt;
  vfc_out_t      out_data_r, out_data_nxt;

  logic [31:0]   cmd_addr_full;
  logic [AW-1:0] cmd_addr;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_ra;
  logic          issuing;
  logic [7:0]    nb_type;
  logic          vis;
  logic [2:0]    sel_face;
  logic [5:0]    rest_mask;
  logic          out_free;

  assign cmd_addr_full = 32'(pop_data.pos_x) + 32'(STRIDE_Z) * 32'(pop_data.pos_z)
                       + 32'(STRIDE_Y) * 32'(pop_data.pos_y);
  assign cmd_addr  = cmd_addr_full[AW-1:0];
  assign pop_ready = (state_r == BS_IDLE);
  assign mem_we    = pop_valid && pop_ready && (pop_data.func == FUNC_WRITE) && pop_data.in_chunk;
  assign issuing   = (state_r == BS_READ) && (step_r != STEP_DONE);
  assign mem_re    = issuing && (src_of_step(cur_r.src, step_r) == SRC_MEM);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    case (step_r)
      3'd0:    mem_ra = base_r;
      3'd1:    mem_ra = base_r - STEP_Z;
      3'd2:    mem_ra = base_r + STEP_Z;
      3'd3:    mem_ra = base_r - STEP_X;
      3'd4:    mem_ra = base_r + STEP_X;
      3'd5:    mem_ra = base_r + STEP_Y;
      default: mem_ra = base_r - STEP_Y;
    endcase
  end

  // Neighbor type and visibility of the face whose read data is back.
  always_comb begin
    case (src_of_step(cur_r.src, dstep_r))
      SRC_MEM:    nb_type = rd_data_r;
      SRC_EDGE_X: nb_type = cur_r.edge_x_type;
      SRC_EDGE_Z: nb_type = cur_r.edge_z_type;
      default:    nb_type = AIR_TYPE;
    endcase
    vis = (self_r != AIR_TYPE) &&
          ((nb_type == AIR_TYPE) ||
           ((nb_type == transparent_type) && (self_r != transparent_type)));
  end

  // Lowest visible face left to report.
  always_comb begin
    sel_face = FACE_BACK;
    for (int i = 5; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel_face = 3'(i);
      end
    end
    rest_mask = mask_r & ~(6'b000001 << sel_face);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    base_nxt      = base_r;
    step_nxt      = step_r;
    dvld_nxt      = issuing;
    dstep_nxt     = step_r;
    self_nxt      = self_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      BS_IDLE: begin
        if (pop_valid && pop_data.func == FUNC_QUERY) begin
          cur_nxt  = pop_data;
          base_nxt = cmd_addr;
          step_nxt = 3'd0;
          mask_nxt = '0;
          state_nxt = pop_data.in_chunk ? BS_READ : BS_EMIT;
        end
      end
      BS_READ: begin
        if (issuing) begin
          step_nxt = step_r + 3'd1;
        end
        if (dvld_r) begin
          if (dstep_r == 3'd0) begin
            self_nxt = rd_data_r;
          end
          for (int i = 0; i < 6; i++) begin
            if (dstep_r == 3'(i + 1)) begin
              mask_nxt[i] = vis;
            end
          end
          if (dstep_r == LAST_STEP) begin
            state_nxt = BS_EMIT;
          end
        end
      end
      BS_EMIT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_data_nxt.out_x   = cur_r.pos_x;
          out_data_nxt.out_y   = cur_r.pos_y;
          out_data_nxt.out_z   = cur_r.pos_z;
          if (mask_r == '0) begin
            out_data_nxt.face_id    = FACE_BACK;
            out_data_nxt.face_valid = 1'b0;
            out_data_nxt.last_face  = 1'b1;
            state_nxt               = BS_IDLE;
          end else begin
            out_data_nxt.face_id    = sel_face;
            out_data_nxt.face_valid = 1'b1;
            out_data_nxt.last_face  = (rest_mask == '0);
            mask_nxt                = rest_mask;
            if (rest_mask == '0) begin
              state_nxt = BS_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      step_r      <= '0;
      dvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      dvld_r      <= dvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    base_r     <= base_nxt;
    dstep_r    <= dstep_nxt;
    self_r     <= self_nxt;
    mask_r     <= mask_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      voxel_mem_r[cmd_addr] <= pop_data.block_type;
    end
    if (mem_re) begin
      rd_data_r <= voxel_mem_r[mem_ra];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_dvld_only_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    dvld_r |-> state_r == BS_READ)
    else $error("read data returned outside the read phase");

  a_no_face_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.face_valid |-> out_data_r.last_face &&
    out_data_r.face_id == FACE_BACK)
    else $error("no-face word malformed");

  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.face_valid |-> out_data_r.face_id <= FACE_BOTTOM)
    else $error("face id out of range");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_EMIT && out_free |=> out_valid_r)
    else $error("emit state did not load a result");
`endif

endmodule

// File: src/voxel_face_cull_core.sv
// Top level of the voxel face cull core.
//
// The core holds one CHUNK_WIDTH x CHUNK_HEIGHT x CHUNK_DEPTH chunk of 8-bit block
// types in a single on-chip memory (one write and one read port, registered read).
// A write word stores one cell and gives no result. A query word gives
// one result word per visible face in the order back, front, left, right, top,
// bottom, with last_face set on the final one; a query with no visible face (air
// cell, buried cell, or coordinates outside the chunk) gives one word with
// face_valid 0, face_id 0 and last_face 1. A query steps through the cell and its
// six neighbors, one per cycle, reading those inside the chunk through the one
// read port; the back end takes the query, issues the seven read steps, waits for
// the last data and then emits its result words. A query outside the chunk skips
// the reads, and a held result keeps the back end in its emit state. A four-entry
// command queue decouples the input side, so new words are taken while a query is
// being worked on. Neighbors across
// the x and z chunk edges come from edge_x_type and edge_z_type (0 when no chunk
// exists); neighbors above the top or below the bottom are air. The transparent
// type register (reset 5) is written through the cfg port, which is always ready;
// write it only while the core is idle. Every cell must be written before a query
// reads it. The memory needs no clearing after reset.
module voxel_face_cull_core #(
  parameter int CHUNK_WIDTH  = 16,
  parameter int CHUNK_HEIGHT = 256,
  parameter int CHUNK_DEPTH  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vfc_pkg::vfc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vfc_pkg::vfc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import vfc_pkg::*;

  logic [7:0] transparent_r, transparent_nxt;
  vfc_cmd_t   front_cmd;
  vfc_cmd_t   q_data;
  logic       q_valid, q_ready;

  // Accept config words every cycle; hold the see-through type otherwise.
  assign cfg_ready       = 1'b1;
  assign transparent_nxt = (cfg_valid && cfg_ready) ? cfg_data : transparent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transparent_r <= TRANSPARENT_RESET;
    end else begin
      transparent_r <= transparent_nxt;
    end
  end

  // Classify the incoming word: range check and where each neighbor comes from.
  vfc_front #(
    .CHUNK_WIDTH  (CHUNK_WIDTH),
    .CHUNK_HEIGHT (CHUNK_HEIGHT),
    .CHUNK_DEPTH  (CHUNK_DEPTH)
  ) u_front (
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  // Buffer classified words; stall the input only when the queue is full.
  vfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (front_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Carry out writes and queries against the voxel memory.
  vfc_back #(
    .CHUNK_WIDTH  (CHUNK_WIDTH),
    .CHUNK_HEIGHT (CHUNK_HEIGHT),
    .CHUNK_DEPTH  (CHUNK_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .transparent_type (transparent_r),
    .pop_valid        (q_valid),
    .pop_ready        (q_ready),
    .pop_data         (q_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule
